// File: design/bir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the bilinear resize core: field widths,
// register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bir_pkg;

    // Field widths of one beat
    localparam int COORD_W   = 9;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int SIZE_W    = 10;
    localparam int INV_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int SX_W      = COORD_W + INV_W;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 24;

    // Operation codes carried in the input tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE  = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 10'd512;
    localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 10'd512;
    localparam logic [INV_W-1:0]  INV_SCALE_RST  = 16'd13653;

    // Neighbor select: bit 0 picks the right column, bit 1 the lower row
    localparam logic [1:0] NB_00 = 2'd0;
    localparam logic [1:0] NB_11 = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAP   = 7'b0000010,
        ST_CHK   = 7'b0000100,
        ST_WGT   = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic       ld_wr;    // write the accepted load beat to the frame memory
        logic       capture;  // latch the output position of a compute beat
        logic       map_en;   // scale the position into source space
        logic       chk_en;   // split, range check and clamp neighbors
        logic       wgt_en;   // form weights and row bases, clear accumulators
        logic       rd_en;    // read one neighbor
        logic [1:0] rd_sel;   // which neighbor
        logic       out_load; // load the result register
    } t_cmd;

    typedef struct packed {
        logic oor;            // mapped position lies outside the frame
    } t_sts;

endpackage

// File: design/bir_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read the addressed word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_ctrl
// Sequencer of the resize core: accepts beats, steps a compute item through
// mapping, checking, weighting, four neighbor reads and drain (skipped outside the frame), and owns result valid.
// ----------------------------------------------------------------------------
module bir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  bir_pkg::t_sts i_sts,
    output bir_pkg::t_cmd o_cmd
);

    import bir_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       slot_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.ld_wr = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_MAP;
                    end
                end
            end
            ST_MAP: begin
                o_cmd.map_en = 1'b1;
                n_state      = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk_en = 1'b1;
                n_state      = ST_WGT;
            end
            ST_WGT: begin
                o_cmd.wgt_en = 1'b1;
                n_cnt        = NB_00;
                n_state      = i_sts.oor ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = r_cnt;
                n_cnt        = r_cnt + 2'd1;
                if (r_cnt == NB_11) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait out the read and product stages
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: design/bir_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_dpath
// Datapath of the resize core: configuration registers, position mapping,
// neighbor clamping, weights, frame memory access and per-channel
// accumulation into the result register.
// ----------------------------------------------------------------------------
module bir_dpath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [bir_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bir_pkg::CFG_DAT_W-1:0]       i_cfg_wr_data,
    input  logic [bir_pkg::IN_DATA_W-1:0]       i_in_data,
    input  bir_pkg::t_cmd                       i_cmd,
    output bir_pkg::t_sts                       o_sts,
    output logic [bir_pkg::OUT_DATA_W-1:0]      o_out_data,
    output logic                                o_out_oor
);

    import bir_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int IW    = SX_W - FRAC_BITS;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int MW    = $clog2(MAXD + 1);
    localparam int CW0   = (IW > MW) ? IW : MW;
    localparam int CMPW  = (CW0 > SIZE_W) ? CW0 : SIZE_W;
    localparam int LDW   = (MW > COORD_W) ? MW : COORD_W;
    localparam int OW    = FRAC_BITS + 1;
    localparam int WW    = 2 * FRAC_BITS + 1;
    localparam int PW    = CHAN_W + WW;
    localparam int ACCW  = 2 * FRAC_BITS + CHAN_W;
    localparam logic [OW-1:0] ONE = OW'(1) << FRAC_BITS;

    // Field slices of the input beat
    logic [COORD_W-1:0] in_col, in_row;
    logic [PIX_W-1:0]   in_pix;
    assign in_col = i_in_data[COORD_W-1:0];
    assign in_row = i_in_data[2*COORD_W-1:COORD_W];
    assign in_pix = i_in_data[2*COORD_W+PIX_W-1:2*COORD_W];

    // Configuration registers
    logic [SIZE_W-1:0] r_src_width, r_src_height;
    logic [INV_W-1:0]  r_inv_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_WIDTH_RST;
            r_src_height <= SRC_HEIGHT_RST;
            r_inv_scale  <= INV_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_wr_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_wr_data[SIZE_W-1:0];
                REG_INV_SCALE:  r_inv_scale  <= i_cfg_wr_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture and map the output position
    logic [COORD_W-1:0] r_col, r_row;
    logic [SX_W-1:0]    r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= in_col;
            r_row <= in_row;
        end
        if (i_cmd.map_en) begin
            r_sx <= SX_W'(r_col) * SX_W'(r_inv_scale);
            r_sy <= SX_W'(r_row) * SX_W'(r_inv_scale);
        end
    end

    // Clamp sizes, range check, clamp right and lower neighbors
    logic [CMPW-1:0] sw, sh, wc, hc, x0c, y0c, x0p, y0p, x1c, y1c;
    logic            oor;

    assign sw  = CMPW'(r_src_width);
    assign sh  = CMPW'(r_src_height);
    assign wc  = (sw == '0) ? CMPW'(1) :
                 (sw > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : sw;
    assign hc  = (sh == '0) ? CMPW'(1) :
                 (sh > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : sh;
    assign x0c = CMPW'(r_sx[SX_W-1:FRAC_BITS]);
    assign y0c = CMPW'(r_sy[SX_W-1:FRAC_BITS]);
    assign x0p = x0c + CMPW'(1);
    assign y0p = y0c + CMPW'(1);
    assign x1c = (x0p >= wc) ? wc - CMPW'(1) : x0p;
    assign y1c = (y0p >= hc) ? hc - CMPW'(1) : y0p;
    assign oor = (x0c >= wc) || (y0c >= hc);

    logic [XW-1:0]        r_x0, r_x1;
    logic [YW-1:0]        r_y0, r_y1;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic                 r_oor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_en) begin
            r_x0  <= XW'(x0c);
            r_x1  <= XW'(x1c);
            r_y0  <= YW'(y0c);
            r_y1  <= YW'(y1c);
            r_fx  <= r_sx[FRAC_BITS-1:0];
            r_fy  <= r_sy[FRAC_BITS-1:0];
            r_oor <= oor;
        end
    end

    assign o_sts.oor = r_oor;

    // Weights and row base addresses
    logic [OW-1:0]   omfx, omfy;
    logic [2*OW-1:0] m00, m10, m01, m11;
    logic [WW-1:0]   r_w [4];
    logic [AW-1:0]   r_base0, r_base1;

    assign omfx = ONE - OW'(r_fx);
    assign omfy = ONE - OW'(r_fy);
    assign m00  = omfx * omfy;
    assign m10  = OW'(r_fx) * omfy;
    assign m01  = omfx * OW'(r_fy);
    assign m11  = OW'(r_fx) * OW'(r_fy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wgt_en) begin
            r_w[0]  <= m00[WW-1:0];
            r_w[1]  <= m10[WW-1:0];
            r_w[2]  <= m01[WW-1:0];
            r_w[3]  <= m11[WW-1:0];
            r_base0 <= AW'(r_y0) * AW'(MAX_WIDTH);
            r_base1 <= AW'(r_y1) * AW'(MAX_WIDTH);
        end
    end

    // Frame memory address: load write or neighbor read
    logic           ld_ok, ram_we;
    logic [AW-1:0]  ld_addr, rd_addr, ram_addr;
    logic [PIX_W-1:0] ram_rdata;

    assign ld_ok    = (LDW'(in_col) < LDW'(MAX_WIDTH)) &&
                      (LDW'(in_row) < LDW'(MAX_HEIGHT));
    assign ld_addr  = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
    assign rd_addr  = (i_cmd.rd_sel[1] ? r_base1 : r_base0) +
                      AW'(i_cmd.rd_sel[0] ? r_x1 : r_x0);
    assign ram_we   = i_cmd.ld_wr && ld_ok;
    assign ram_addr = i_cmd.ld_wr ? ld_addr : rd_addr;

    bir_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (in_pix),
        .o_rdata (ram_rdata)
    );

    // Track reads through the product stage
    logic       r_rd_vld, r_prod_vld;
    logic [1:0] r_rd_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_prod_vld <= r_rd_vld;
        end
        r_rd_sel <= i_cmd.rd_sel;
    end

    // Weight each channel, then accumulate
    logic [ACCW-1:0] r_prod [3];
    logic [ACCW-1:0] r_acc  [3];
    logic [PW-1:0]   prod   [3];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        assign prod[c] = PW'(ram_rdata[c*CHAN_W +: CHAN_W]) * PW'(r_w[r_rd_sel]);

        always_ff @(posedge i_clk) begin
            r_prod[c] <= prod[c][ACCW-1:0];
            if (i_cmd.wgt_en) begin
                r_acc[c] <= '0;
            end else if (r_prod_vld) begin
                r_acc[c] <= r_acc[c] + r_prod[c];
            end
        end
    end

    // Result register: truncate, or zeros when outside the frame
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_oor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_oor) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {r_acc[2][2*FRAC_BITS +: CHAN_W],
                               r_acc[1][2*FRAC_BITS +: CHAN_W],
                               r_acc[0][2*FRAC_BITS +: CHAN_W]};
            end
            r_out_oor <= r_oor;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_oor  = r_out_oor;

endmodule

// File: design/bilinear_image_resize_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_core
// Frame-store bilinear resizer for three-channel 8-bit pixels. Load beats
// fill the frame memory; compute beats give one interpolated pixel each.
//
//   channel   direction  tdata (low bit up)               tuser
//   s_axis    in         col, row, blue, green, red        op (0 load, 1 compute)
//   m_axis    out        blue, green, red                  out_of_range
//   cfg       in         write enable, index, data         -
//
// Loads stream at one per cycle while no compute is in progress.
// A compute beat steps through map, check, weight, four serial reads of the
// single-port frame memory and drain (outside the frame the reads and drain are
// skipped); ready returns as the result register is loaded, not before.
// A finished result waits in the output register while the next beat enters;
// a compute holds its last step until that register is free.
// Reset clears control and configuration; frame memory holds no reset value.
// ----------------------------------------------------------------------------
module bilinear_image_resize_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bir_pkg::CFG_DAT_W-1:0]     i_cfg_wr_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bir_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // col, row, blue, green, red
    input  logic [0:0]                        s_axis_tuser,  // op
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bir_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // blue, green, red
    output logic [0:0]                        m_axis_tuser   // out_of_range
);

    import bir_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic out_oor;

    bir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bir_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_data    (m_axis_tdata),
        .o_out_oor     (out_oor)
    );

    assign m_axis_tuser[0] = out_oor;

endmodule
